// ----- hw/rtl/sdfi_pkg.sv -----
// ----------------------------------------------------------------------------
// sdfi_pkg
// Shared constants for the segment/disk free interval core.
// ----------------------------------------------------------------------------
package sdfi_pkg;

  localparam int unsigned COORD_WIDTH_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF   = 16;

  // epsilon register
  localparam int unsigned EPS_W     = 31;
  localparam int unsigned EPS_RESET = 65536;

  // config port
  localparam int unsigned APB_AW           = 3;
  localparam int unsigned APB_DW           = 32;
  localparam logic [APB_AW-1:0] REG_EPSILON = 3'd0;

  // partial product slice width of the wide multipliers
  localparam int unsigned MUL_CHUNK = 32;

endpackage

// ----- hw/rtl/sdfi_if.sv -----
// ----------------------------------------------------------------------------
// sdfi_if
// Valid/ready channels carrying one query item and one interval result item.
// ----------------------------------------------------------------------------
interface sdfi_in_if #(
  parameter int unsigned COORD_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] seg_start_x;
  logic signed [COORD_WIDTH-1:0] seg_start_y;
  logic signed [COORD_WIDTH-1:0] seg_end_x;
  logic signed [COORD_WIDTH-1:0] seg_end_y;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;

  modport source (
    output valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y, point_x, point_y,
    input  ready
  );
  modport sink (
    input  valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y, point_x, point_y,
    output ready
  );
endinterface

interface sdfi_out_if #(
  parameter int unsigned FRAC_BITS = 16
);
  logic               valid;
  logic               ready;
  logic               is_empty;
  logic [FRAC_BITS:0] frac_low;
  logic [FRAC_BITS:0] frac_high;
  logic               left_included;
  logic               right_included;

  modport source (
    output valid, is_empty, frac_low, frac_high, left_included, right_included,
    input  ready
  );
  modport sink (
    input  valid, is_empty, frac_low, frac_high, left_included, right_included,
    output ready
  );
endinterface

// ----- hw/rtl/sdfi_mul.sv -----
// ----------------------------------------------------------------------------
// sdfi_mul
// Two-stage unsigned wide multiplier: sliced partial products, then their sum.
// ----------------------------------------------------------------------------
module sdfi_mul
  import sdfi_pkg::*;
#(
  parameter int unsigned A_W    = 64,
  parameter int unsigned B_W    = 64,
  parameter int unsigned SIDE_W = 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [A_W-1:0]       a_i,
  input  logic [B_W-1:0]       b_i,
  input  logic [SIDE_W-1:0]    side_i,
  output logic                 valid_o,
  output logic [A_W+B_W-1:0]   prod_o,
  output logic [SIDE_W-1:0]    side_o
);

  localparam int unsigned NA    = (A_W + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int unsigned NB    = (B_W + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int unsigned NP    = NA * NB;
  localparam int unsigned ACC_W = (NA + NB) * MUL_CHUNK;

  logic [NA*MUL_CHUNK-1:0]   a_ext;
  logic [NB*MUL_CHUNK-1:0]   b_ext;
  logic [2*MUL_CHUNK-1:0]    pp_d [NP];
  logic [2*MUL_CHUNK-1:0]    pp_q [NP];
  logic [ACC_W-1:0]          acc;
  logic                      v1_q, v2_q;
  logic [SIDE_W-1:0]         s1_q, s2_q;
  logic [A_W+B_W-1:0]        prod_q;

  assign a_ext = (NA*MUL_CHUNK)'(a_i);
  assign b_ext = (NB*MUL_CHUNK)'(b_i);

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        pp_d[i*NB+j] = (2*MUL_CHUNK)'(a_ext[i*MUL_CHUNK +: MUL_CHUNK])
                     * (2*MUL_CHUNK)'(b_ext[j*MUL_CHUNK +: MUL_CHUNK]);
      end
    end
  end

  always_comb begin
    acc = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        acc = acc + (ACC_W'(pp_q[i*NB+j]) << ((i + j) * MUL_CHUNK));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pp_q   <= pp_d;
      s1_q   <= side_i;
      prod_q <= acc[A_W+B_W-1:0];
      s2_q   <= s1_q;
    end
  end

  assign valid_o = v2_q;
  assign prod_o  = prod_q;
  assign side_o  = s2_q;

endmodule

// ----- hw/rtl/sdfi_sqrt.sv -----
// ----------------------------------------------------------------------------
// sdfi_sqrt
// Pipelined integer square root, one root bit per stage (floor result).
// ----------------------------------------------------------------------------
module sdfi_sqrt
  import sdfi_pkg::*;
#(
  parameter int unsigned D_W    = 130,
  parameter int unsigned SIDE_W = 1,
  localparam int unsigned R_W   = (D_W + 1) / 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [D_W-1:0]    rad_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [R_W-1:0]    root_o,
  output logic [SIDE_W-1:0] side_o
);

  logic [2*R_W-1:0]  rad_q  [R_W];
  logic [R_W+1:0]    rem_q  [R_W];
  logic [R_W-1:0]    root_q [R_W];
  logic              v_q    [R_W];
  logic [SIDE_W-1:0] side_q [R_W];

  for (genvar i = 0; i < R_W; i++) begin : g_stage
    logic [2*R_W-1:0]  rad_in;
    logic [R_W+1:0]    rem_in;
    logic [R_W-1:0]    root_in;
    logic              v_in;
    logic [SIDE_W-1:0] side_in;
    logic [R_W+1:0]    rem_sh, trial, rem_d;
    logic              fits;

    if (i == 0) begin : g_first
      assign rad_in  = (2*R_W)'(rad_i);
      assign rem_in  = '0;
      assign root_in = '0;
      assign v_in    = valid_i;
      assign side_in = side_i;
    end else begin : g_next
      assign rad_in  = rad_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
      assign v_in    = v_q[i-1];
      assign side_in = side_q[i-1];
    end

    // bring down the next two radicand bits and try root*4+1
    always_comb begin
      rem_sh = {rem_in[R_W-1:0], rad_in[2*R_W-1 -: 2]};
      trial  = {root_in, 2'b01};
      fits   = (rem_sh >= trial);
      rem_d  = fits ? (rem_sh - trial) : rem_sh;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (en_i) begin
        v_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[i]  <= rad_in << 2;
        rem_q[i]  <= rem_d;
        root_q[i] <= {root_in[R_W-2:0], fits};
        side_q[i] <= side_in;
      end
    end
  end

  assign valid_o = v_q[R_W-1];
  assign root_o  = root_q[R_W-1];
  assign side_o  = side_q[R_W-1];

endmodule

// ----- hw/rtl/sdfi_div.sv -----
// ----------------------------------------------------------------------------
// sdfi_div
// Pipelined restoring divider giving floor(num * 2^(Q_W-1) / den), num <= den.
// ----------------------------------------------------------------------------
module sdfi_div
  import sdfi_pkg::*;
#(
  parameter int unsigned N_W    = 65,
  parameter int unsigned Q_W    = 17,
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [N_W-1:0]    num_i,
  input  logic [N_W-1:0]    den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [Q_W-1:0]    quot_o,
  output logic [SIDE_W-1:0] side_o
);

  logic [N_W:0]      rem_q  [Q_W];
  logic [N_W-1:0]    den_q  [Q_W];
  logic [Q_W-1:0]    quot_q [Q_W];
  logic              v_q    [Q_W];
  logic [SIDE_W-1:0] side_q [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    logic [N_W:0]      x, rem_d;
    logic [N_W-1:0]    den_in;
    logic [Q_W-1:0]    quot_in;
    logic              v_in;
    logic [SIDE_W-1:0] side_in;
    logic              fits;

    if (k == 0) begin : g_first
      assign x       = {1'b0, num_i};
      assign den_in  = den_i;
      assign quot_in = '0;
      assign v_in    = valid_i;
      assign side_in = side_i;
    end else begin : g_next
      // remainder stays below den, so the shift cannot overflow
      assign x       = {rem_q[k-1][N_W-1:0], 1'b0};
      assign den_in  = den_q[k-1];
      assign quot_in = quot_q[k-1];
      assign v_in    = v_q[k-1];
      assign side_in = side_q[k-1];
    end

    always_comb begin
      fits  = (x >= {1'b0, den_in});
      rem_d = fits ? (x - {1'b0, den_in}) : x;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d;
        den_q[k]  <= den_in;
        quot_q[k] <= {quot_in[Q_W-2:0], fits};
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = v_q[Q_W-1];
  assign quot_o  = quot_q[Q_W-1];
  assign side_o  = side_q[Q_W-1];

endmodule

// ----- hw/rtl/segment_disk_free_interval_core.sv -----
// ----------------------------------------------------------------------------
// segment_disk_free_interval_core
// Free-space interval of a segment against a disk of radius epsilon.
//
//   channel   dir  handshake      payload
//   item_in   in   valid/ready    segment start/end, query point
//   result    out  valid/ready    empty flag, low/high fraction, end flags
//   apb       in   psel/penable   epsilon register
//
// Stages from input to result: differences, products, length, multipliers,
// discriminant, sqrt (R_W stages, one root bit each), bounds, dividers, output
// register. One item enters per cycle unless the pipe is stalled; the whole
// pipe advances together and stalls only while a result sits in the output
// register untaken. Reset clears all valid bits and loads epsilon with 1.0.
// ----------------------------------------------------------------------------
module segment_disk_free_interval_core
  import sdfi_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int unsigned FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  sdfi_in_if.sink           item_in,
  sdfi_out_if.source        result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int unsigned CW    = COORD_WIDTH;
  localparam int unsigned DIF_W = CW + 1;
  localparam int unsigned PRD_W = 2 * CW + 1;
  localparam int unsigned L2_W  = 2 * CW + 1;
  localparam int unsigned A_W   = 2 * CW + 2;
  localparam int unsigned CM_W  = 2 * CW + 1;
  localparam int unsigned E2_W  = 2 * EPS_W;
  localparam int unsigned EL_W  = E2_W + L2_W;
  localparam int unsigned C2_W  = 2 * CM_W;
  localparam int unsigned D_W   = (EL_W > C2_W) ? EL_W : C2_W;
  localparam int unsigned R_W   = (D_W + 1) / 2;
  localparam int unsigned X_W   = ((A_W > R_W + 1) ? A_W : R_W + 1) + 1;
  localparam int unsigned Q_W   = FRAC_BITS + 1;

  // ---------------- config register ----------------
  logic [EPS_W-1:0] eps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= EPS_W'(EPS_RESET);
    end else if (psel && penable && pwrite && paddr == REG_EPSILON) begin
      eps_q <= pwdata[EPS_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == REG_EPSILON) ? APB_DW'(eps_q) : '0;

  // ---------------- pipeline control ----------------
  logic en;
  logic out_valid_q;

  assign en            = !out_valid_q || result.ready;
  assign item_in.ready = en;

  // ---------------- stage 1: differences ----------------
  logic                    v1_q;
  logic signed [DIF_W-1:0] dx_q, dy_q, wx_q, wy_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx_q <= DIF_W'(item_in.seg_end_x) - DIF_W'(item_in.seg_start_x);
      dy_q <= DIF_W'(item_in.seg_end_y) - DIF_W'(item_in.seg_start_y);
      wx_q <= DIF_W'(item_in.point_x) - DIF_W'(item_in.seg_start_x);
      wy_q <= DIF_W'(item_in.point_y) - DIF_W'(item_in.seg_start_y);
    end
  end

  // ---------------- stage 2: products ----------------
  logic                    v2_q;
  logic signed [PRD_W-1:0] xx_q, yy_q, ax_q, ay_q, cx_q, cy_q;
  logic [E2_W-1:0]         e2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      xx_q <= PRD_W'(dx_q) * PRD_W'(dx_q);
      yy_q <= PRD_W'(dy_q) * PRD_W'(dy_q);
      ax_q <= PRD_W'(dx_q) * PRD_W'(wx_q);
      ay_q <= PRD_W'(dy_q) * PRD_W'(wy_q);
      cx_q <= PRD_W'(dx_q) * PRD_W'(wy_q);
      cy_q <= PRD_W'(dy_q) * PRD_W'(wx_q);
      e2_q <= E2_W'(eps_q) * E2_W'(eps_q);
    end
  end

  // ---------------- stage 3: length, projection, cross ----------------
  logic                  v3_q;
  logic [L2_W-1:0]       l2_q;
  logic signed [A_W-1:0] a_q;
  logic [CM_W-1:0]       cmag_q;
  logic                  l2z_q;
  logic [E2_W-1:0]       e2b_q;
  logic [L2_W-1:0]       l2_d;
  logic signed [A_W-1:0] c_d;

  always_comb begin
    l2_d = $unsigned(xx_q) + $unsigned(yy_q);
    c_d  = A_W'(cx_q) - A_W'(cy_q);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      l2_q   <= l2_d;
      l2z_q  <= (l2_d == '0);
      a_q    <= A_W'(ax_q) + A_W'(ay_q);
      cmag_q <= c_d[A_W-1] ? CM_W'(-c_d) : CM_W'(c_d);
      e2b_q  <= e2_q;
    end
  end

  // ---------------- stages 4-5: eps^2 * L2 and C^2 ----------------
  logic                  ve_v, vc_v;
  logic [EL_W-1:0]       el_v;
  logic [C2_W-1:0]       c2_v;
  logic signed [A_W-1:0] a_m;
  logic                  l2z_m;
  logic [L2_W-1:0]       l2_m;

  sdfi_mul #(.A_W(E2_W), .B_W(L2_W), .SIDE_W(A_W + 1)) u_mul_e (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(v3_q), .a_i(e2b_q), .b_i(l2_q), .side_i({a_q, l2z_q}),
    .valid_o(ve_v), .prod_o(el_v), .side_o({a_m, l2z_m})
  );

  sdfi_mul #(.A_W(CM_W), .B_W(CM_W), .SIDE_W(L2_W)) u_mul_c (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(v3_q), .a_i(cmag_q), .b_i(cmag_q), .side_i(l2_q),
    .valid_o(vc_v), .prod_o(c2_v), .side_o(l2_m)
  );

  // ---------------- stage 6: discriminant ----------------
  logic                  v6_q;
  logic [D_W-1:0]        dmag_q;
  logic signed [A_W-1:0] a6_q;
  logic [L2_W-1:0]       l26_q;
  logic                  emp6_q;
  logic [D_W:0]          d_full;

  assign d_full = {1'b0, D_W'(el_v)} - {1'b0, D_W'(c2_v)};

  always_ff @(posedge clk_i) begin
    if (en) begin
      dmag_q <= d_full[D_W-1:0];
      a6_q   <= a_m;
      l26_q  <= l2_m;
      emp6_q <= l2z_m || d_full[D_W];
    end
  end

  // ---------------- sqrt ----------------
  logic                  vs_v;
  logic [R_W-1:0]        root_v;
  logic signed [A_W-1:0] a_s;
  logic [L2_W-1:0]       l2_s;
  logic                  emp_s;

  sdfi_sqrt #(.D_W(D_W), .SIDE_W(A_W + L2_W + 1)) u_sqrt (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(v6_q), .rad_i(dmag_q), .side_i({a6_q, l26_q, emp6_q}),
    .valid_o(vs_v), .root_o(root_v), .side_o({a_s, l2_s, emp_s})
  );

  // ---------------- stage 7: bounds, flags, clamp ----------------
  logic                  v7_q;
  logic [L2_W-1:0]       nlo_q, nhi_q, l27_q;
  logic                  emp7_q, left7_q, right7_q;
  logic signed [X_W-1:0] lo, hi, l2x;
  logic                  right_d;

  always_comb begin
    lo      = X_W'(a_s) - X_W'($signed({1'b0, root_v}));
    hi      = X_W'(a_s) + X_W'($signed({1'b0, root_v}));
    l2x     = X_W'($signed({1'b0, l2_s}));
    right_d = (hi >= l2x);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      emp7_q   <= emp_s || (lo > l2x) || hi[X_W-1];
      left7_q  <= (lo <= 0);
      right7_q <= right_d;
      nlo_q    <= lo[X_W-1] ? '0 : lo[L2_W-1:0];
      nhi_q    <= right_d ? l2_s : hi[L2_W-1:0];
      l27_q    <= l2_s;
    end
  end

  // ---------------- fraction dividers ----------------
  logic           vl_v, vh_v;
  logic [Q_W-1:0] qlo_v, qhi_v;
  logic           emp_v, left_v, right_v;

  sdfi_div #(.N_W(L2_W), .Q_W(Q_W), .SIDE_W(2)) u_div_lo (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(v7_q), .num_i(nlo_q), .den_i(l27_q), .side_i({emp7_q, left7_q}),
    .valid_o(vl_v), .quot_o(qlo_v), .side_o({emp_v, left_v})
  );

  sdfi_div #(.N_W(L2_W), .Q_W(Q_W), .SIDE_W(1)) u_div_hi (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(v7_q), .num_i(nhi_q), .den_i(l27_q), .side_i(right7_q),
    .valid_o(vh_v), .quot_o(qhi_v), .side_o(right_v)
  );

  // ---------------- valid bits of the local stages ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v6_q        <= 1'b0;
      v7_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q        <= item_in.valid;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      v6_q        <= ve_v && vc_v;
      v7_q        <= vs_v;
      out_valid_q <= vl_v && vh_v;
    end
  end

  // ---------------- output register ----------------
  logic               emp_q, left_q, right_q;
  logic [FRAC_BITS:0] flo_q, fhi_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      emp_q   <= emp_v;
      flo_q   <= emp_v ? '0 : qlo_v;
      fhi_q   <= emp_v ? '0 : qhi_v;
      left_q  <= !emp_v && left_v;
      right_q <= !emp_v && right_v;
    end
  end

  assign result.valid          = out_valid_q;
  assign result.is_empty       = emp_q;
  assign result.frac_low       = flo_q;
  assign result.frac_high      = fhi_q;
  assign result.left_included  = left_q;
  assign result.right_included = right_q;

endmodule
